// ===== rtl/mi4_pkg.sv =====
package mi4_pkg;

   localparam int NUM_ELEMS  = 16;
   localparam int DIGIT_BITS = 16;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

// ===== rtl/mi4_front.sv =====
module mi4_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_ready,
   input  logic signed [DATA_WIDTH-1:0]                    req_elem_value,
   input  mi4_pkg::q_status_type                           q_status,
   output logic                                            push,
   output logic [mi4_pkg::NUM_ELEMS-1:0][DATA_WIDTH-1:0]   push_matrix
);
   import mi4_pkg::*;

   logic [3:0]            load_count_ff, load_count_in;
   logic [DATA_WIDTH-1:0] stage_ff [NUM_ELEMS-1];
   logic                  take;

   // hold the last element while the queue has no room for the matrix
   assign req_ready = !((load_count_ff == 4'(NUM_ELEMS - 1)) && q_status.full);
   assign take      = req_valid && req_ready;
   assign push      = take && (load_count_ff == 4'(NUM_ELEMS - 1));

   always_comb begin
      load_count_in = load_count_ff;
      if (take) begin
         load_count_in = load_count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !push) begin
         stage_ff[load_count_ff] <= req_elem_value;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_ELEMS - 1; k++) begin
         push_matrix[k] = stage_ff[k];
      end
      push_matrix[NUM_ELEMS-1] = req_elem_value;
   end

endmodule

// ===== rtl/mi4_queue.sv =====
module mi4_queue #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            push,
   input  logic [mi4_pkg::NUM_ELEMS-1:0][DATA_WIDTH-1:0]   push_matrix,
   input  logic                                            pop,
   output mi4_pkg::q_status_type                           status,
   output logic [mi4_pkg::NUM_ELEMS-1:0][DATA_WIDTH-1:0]   head
);
   import mi4_pkg::*;

   logic [NUM_ELEMS-1:0][DATA_WIDTH-1:0] mem_ff [2];
   logic                                 wr_ptr_ff;
   logic                                 rd_ptr_ff;
   logic [1:0]                           count_ff;

   assign status.full      = (count_ff == 2'd2);
   assign status.not_empty = (count_ff != 2'd0);
   assign head             = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_matrix;
      end
   end

endmodule

// ===== rtl/mi4_mul.sv =====
module mi4_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 99
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic                              done,
   output logic signed [A_WIDTH+B_WIDTH-1:0] prod
);
   import mi4_pkg::*;

   localparam int ND  = (B_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int BMW = ND * DIGIT_BITS;
   localparam int ACW = A_WIDTH + BMW;
   localparam int PW  = A_WIDTH + B_WIDTH;
   localparam int CW  = $clog2(ND + 1);

   logic [CW-1:0]          cnt_ff;
   logic                   fin_ff;
   logic                   done_ff;
   logic [A_WIDTH-1:0]     amag_ff;
   logic [BMW-1:0]         bmag_ff;
   logic [ACW-1:0]         acc_ff;
   logic                   neg_ff;
   logic signed [PW-1:0]   prod_ff;
   logic [A_WIDTH-1:0]     amag;
   logic [B_WIDTH-1:0]     bmag;
   logic [PW-1:0]          acc_low;

   assign amag    = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
   assign bmag    = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
   assign acc_low = acc_ff[PW-1:0];
   assign done    = done_ff;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(ND);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   // one digit of b per cycle, most significant digit first
   always_ff @(posedge clock) begin
      if (start) begin
         amag_ff <= amag;
         bmag_ff <= BMW'(bmag);
         neg_ff  <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
         acc_ff  <= '0;
      end else if (cnt_ff != '0) begin
         acc_ff  <= (acc_ff << DIGIT_BITS)
                  + ACW'(amag_ff * bmag_ff[BMW-1 -: DIGIT_BITS]);
         bmag_ff <= bmag_ff << DIGIT_BITS;
      end
      if (fin_ff) begin
         prod_ff <= neg_ff ? PW'(-acc_low) : acc_low;
      end
   end

endmodule

// ===== rtl/mi4_div.sv =====
module mi4_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int NUM_WIDTH  = 99,
   parameter int DEN_WIDTH  = 133
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_WIDTH-1:0] num,
   input  logic signed [DEN_WIDTH-1:0] den,
   output logic                        done,
   output logic [DATA_WIDTH-1:0]       quot,
   output logic                        sat
);
   localparam int XA = NUM_WIDTH + 2 * FRAC_BITS + 2;
   localparam int XB = DEN_WIDTH + DATA_WIDTH + 2;
   localparam int XW = (XA > XB) ? XA : XB;
   localparam int CW = $clog2(DATA_WIDTH + 1);
   localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MINMAG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_ITER,
      D_FINAL
   } div_state_type;

   div_state_type          state_ff;
   logic [XW-1:0]          rem_ff;
   logic [XW-1:0]          dsh_ff;
   logic [DATA_WIDTH-1:0]  q_ff;
   logic                   neg_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   done_ff;
   logic [DATA_WIDTH-1:0]  quot_ff;
   logic                   sat_ff;
   logic [NUM_WIDTH-1:0]   nmag;
   logic [DEN_WIDTH-1:0]   dmag;
   logic [DATA_WIDTH-1:0]  lim;
   logic                   fits;

   assign nmag = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
   assign dmag = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
   assign lim  = neg_ff ? MINMAG : MAXPOS;
   assign fits = (rem_ff >= dsh_ff);
   assign done = done_ff;
   assign quot = quot_ff;
   assign sat  = sat_ff;

   // round half away from zero: floor((2|n|*2^2F + |d|) / 2|d|)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff   <= (XW'(nmag) << (2 * FRAC_BITS + 1)) + XW'(dmag);
                  dsh_ff   <= XW'(dmag) << (DATA_WIDTH + 1);
                  neg_ff   <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               if (fits) begin
                  quot_ff  <= neg_ff ? MINMAG : MAXPOS;
                  sat_ff   <= 1'b1;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  dsh_ff   <= dsh_ff >> 1;
                  q_ff     <= '0;
                  cnt_ff   <= CW'(DATA_WIDTH);
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               if (fits) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               q_ff   <= {q_ff[DATA_WIDTH-2:0], fits};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= D_FINAL;
               end
            end
            D_FINAL: begin
               if (q_ff > lim) begin
                  quot_ff <= neg_ff ? DATA_WIDTH'(-lim) : lim;
                  sat_ff  <= 1'b1;
               end else begin
                  quot_ff <= neg_ff ? DATA_WIDTH'(-q_ff) : q_ff;
                  sat_ff  <= 1'b0;
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/mi4_back.sv =====
module mi4_back #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  mi4_pkg::q_status_type                           q_status,
   input  logic [mi4_pkg::NUM_ELEMS-1:0][DATA_WIDTH-1:0]   head,
   output logic                                            pop,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic signed [DATA_WIDTH-1:0]                    rsp_inv_value,
   output logic [3:0]                                      rsp_elem_index,
   output logic                                            rsp_is_last,
   output logic                                            rsp_singular,
   output logic                                            rsp_saturated
);
   import mi4_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int DW2 = 2 * W + 1;
   localparam int CW  = 3 * W + 3;
   localparam int DTW = 4 * W + 5;
   localparam int PW  = W + CW;
   localparam logic [W-1:0] MAXPOS  = {1'b0, {(W-1){1'b1}}};
   localparam logic         ONE_SAT = (FRAC_BITS >= DATA_WIDTH - 1);
   localparam logic [W-1:0] ONE_VAL = ONE_SAT ? MAXPOS : (W'(1) << FRAC_BITS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_COPY,
      S_FETCH,
      S_MUL,
      S_WAIT,
      S_RDC,
      S_DIV,
      S_DWAIT,
      S_PUT
   } state_type;

   typedef enum logic [3:0] {
      OP_M11M22,
      OP_M12M21,
      OP_M10M22,
      OP_M12M20,
      OP_M10M21,
      OP_M11M20,
      OP_T0,
      OP_T1,
      OP_T2,
      OP_DET
   } op_type;

   state_type             state_ff;
   op_type                op_ff;
   logic [3:0]            idx_ff;
   logic [3:0]            ci_ff;
   logic [W-1:0]          m_mem [NUM_ELEMS];
   logic signed [CW-1:0]  cof_mem [NUM_ELEMS];
   logic signed [W-1:0]   ma_ff;
   logic signed [W-1:0]   mb_ff;
   logic signed [DW2-1:0] d_ff [3];
   logic signed [CW-1:0]  cacc_ff;
   logic signed [CW-1:0]  cofv_ff;
   logic signed [CW-1:0]  cofr_ff;
   logic signed [DTW-1:0] det_ff;
   logic                  rsp_valid_ff;
   logic [W-1:0]          rsp_value_ff;
   logic [3:0]            rsp_index_ff;
   logic                  rsp_last_ff;
   logic                  rsp_sing_ff;
   logic                  rsp_sat_ff;

   logic [1:0]            row;
   logic [1:0]            col;
   logic [3:0]            addr_a;
   logic [3:0]            addr_b;
   logic signed [CW-1:0]  mul_b;
   logic                  mul_start;
   logic                  mul_done;
   logic signed [PW-1:0]  prod;
   logic                  div_start;
   logic                  div_done;
   logic [W-1:0]          div_quot;
   logic                  div_sat;
   logic signed [CW-1:0]  cof_sum;
   logic signed [CW-1:0]  cof_next;
   logic                  singular;
   logic                  diag;
   logic                  out_free;
   logic                  put_fire;
   logic                  cof_last;

   function automatic logic [3:0] mpos(input logic [1:0] r, input logic [1:0] c,
                                       input logic [1:0] i, input logic [1:0] j);
      return {2'(r + i + 2'd1), 2'(c + j + 2'd1)};
   endfunction

   assign row = ci_ff[3:2];
   assign col = ci_ff[1:0];

   always_comb begin
      addr_a = mpos(row, col, 2'd0, 2'd0);
      addr_b = mpos(row, col, 2'd2, 2'd2);
      mul_b  = CW'(mb_ff);
      case (op_ff)
         OP_M11M22: begin
            addr_a = mpos(row, col, 2'd1, 2'd1);
            addr_b = mpos(row, col, 2'd2, 2'd2);
         end
         OP_M12M21: begin
            addr_a = mpos(row, col, 2'd1, 2'd2);
            addr_b = mpos(row, col, 2'd2, 2'd1);
         end
         OP_M10M22: begin
            addr_a = mpos(row, col, 2'd1, 2'd0);
            addr_b = mpos(row, col, 2'd2, 2'd2);
         end
         OP_M12M20: begin
            addr_a = mpos(row, col, 2'd1, 2'd2);
            addr_b = mpos(row, col, 2'd2, 2'd0);
         end
         OP_M10M21: begin
            addr_a = mpos(row, col, 2'd1, 2'd0);
            addr_b = mpos(row, col, 2'd2, 2'd1);
         end
         OP_M11M20: begin
            addr_a = mpos(row, col, 2'd1, 2'd1);
            addr_b = mpos(row, col, 2'd2, 2'd0);
         end
         OP_T0: begin
            addr_a = mpos(row, col, 2'd0, 2'd0);
            mul_b  = CW'(d_ff[0]);
         end
         OP_T1: begin
            addr_a = mpos(row, col, 2'd0, 2'd1);
            mul_b  = CW'(d_ff[1]);
         end
         OP_T2: begin
            addr_a = mpos(row, col, 2'd0, 2'd2);
            mul_b  = CW'(d_ff[2]);
         end
         OP_DET: begin
            addr_a = {2'b00, col};
            mul_b  = cofv_ff;
         end
         default: begin
            addr_a = '0;
            addr_b = '0;
         end
      endcase
   end

   assign cof_sum   = cacc_ff + CW'(prod);
   assign cof_next  = (row[0] ^ col[0]) ? -cof_sum : cof_sum;
   assign cof_last  = (op_ff == OP_DET) || ((op_ff == OP_T2) && (row != 2'd0));
   assign singular  = (det_ff == '0);
   assign diag      = (idx_ff[3:2] == idx_ff[1:0]);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign put_fire  = (state_ff == S_PUT) && out_free;
   assign pop       = (state_ff == S_COPY) && (idx_ff == 4'(NUM_ELEMS - 1));
   assign mul_start = (state_ff == S_MUL);
   assign div_start = (state_ff == S_DIV);

   mi4_mul #(
      .A_WIDTH (W),
      .B_WIDTH (CW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (ma_ff),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   mi4_div #(
      .DATA_WIDTH (W),
      .FRAC_BITS  (FRAC_BITS),
      .NUM_WIDTH  (CW),
      .DEN_WIDTH  (DTW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cofr_ff),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot),
      .sat   (div_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         ci_ff        <= '0;
         op_ff        <= OP_M11M22;
      end else begin
         if (rsp_ready && !put_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_status.not_empty) begin
                  idx_ff   <= '0;
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               m_mem[idx_ff] <= head[idx_ff];
               if (idx_ff == 4'(NUM_ELEMS - 1)) begin
                  ci_ff    <= '0;
                  op_ff    <= OP_M11M22;
                  det_ff   <= '0;
                  state_ff <= S_FETCH;
               end else begin
                  idx_ff <= idx_ff + 4'd1;
               end
            end
            S_FETCH: begin
               ma_ff    <= m_mem[addr_a];
               mb_ff    <= m_mem[addr_b];
               state_ff <= S_MUL;
            end
            S_MUL: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_M11M22: d_ff[0] <= DW2'(prod);
                     OP_M12M21: d_ff[0] <= d_ff[0] - DW2'(prod);
                     OP_M10M22: d_ff[1] <= DW2'(prod);
                     OP_M12M20: d_ff[1] <= d_ff[1] - DW2'(prod);
                     OP_M10M21: d_ff[2] <= DW2'(prod);
                     OP_M11M20: d_ff[2] <= d_ff[2] - DW2'(prod);
                     OP_T0:     cacc_ff <= CW'(prod);
                     OP_T1:     cacc_ff <= cacc_ff - CW'(prod);
                     OP_T2: begin
                        cofv_ff        <= cof_next;
                        cof_mem[ci_ff] <= cof_next;
                     end
                     OP_DET:    det_ff  <= det_ff + DTW'(prod);
                     default: begin
                        cacc_ff <= cacc_ff;
                     end
                  endcase
                  if (cof_last) begin
                     op_ff <= OP_M11M22;
                     if (ci_ff == 4'(NUM_ELEMS - 1)) begin
                        idx_ff   <= '0;
                        state_ff <= S_RDC;
                     end else begin
                        ci_ff    <= ci_ff + 4'd1;
                        state_ff <= S_FETCH;
                     end
                  end else begin
                     op_ff    <= op_type'(op_ff + 4'd1);
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_RDC: begin
               // inverse is the transposed cofactor matrix over the determinant
               cofr_ff  <= cof_mem[{idx_ff[1:0], idx_ff[3:2]}];
               state_ff <= singular ? S_PUT : S_DIV;
            end
            S_DIV: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  state_ff <= S_PUT;
               end
            end
            S_PUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= idx_ff;
                  rsp_last_ff  <= (idx_ff == 4'(NUM_ELEMS - 1));
                  rsp_sing_ff  <= singular;
                  if (singular) begin
                     rsp_value_ff <= diag ? ONE_VAL : '0;
                     rsp_sat_ff   <= diag && ONE_SAT;
                  end else begin
                     rsp_value_ff <= div_quot;
                     rsp_sat_ff   <= div_sat;
                  end
                  if (idx_ff == 4'(NUM_ELEMS - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 4'd1;
                     state_ff <= S_RDC;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inv_value  = rsp_value_ff;
   assign rsp_elem_index = rsp_index_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_singular   = rsp_sing_ff;
   assign rsp_saturated  = rsp_sat_ff;

`ifndef SYNTHESIS
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_index_ff == 4'(NUM_ELEMS - 1))))
      else $error("is_last does not match the final index");

   a_singular_off_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sing_ff && (rsp_index_ff[3:2] != rsp_index_ff[1:0]))
      |-> ((rsp_value_ff == '0) && !rsp_sat_ff))
      else $error("singular result off the diagonal is not zero");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/matrix_inverse_4x4.sv =====
// channel  direction  transfer                         fields
// req      in         one matrix element, row-major    elem_value
// rsp      out        one inverse element, row-major   inv_value, elem_index, is_last,
//                                                      singular, saturated
//
// Elements are taken one per cycle, but the last one of a matrix waits while the queue is full;
// a two-deep matrix queue lets loading run ahead. Each matrix then goes through a copy of its 16
// elements, 148 products on the shared digit-serial multiplier and, unless it is singular, 16
// results from the bit-serial divider.
// Reset (synchronous) empties the queue and clears the load count.
// A stalled rsp holds the back end only; req keeps loading until a matrix is complete and the queue is full.
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_elem_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_value,
   output logic [3:0]                   rsp_elem_index,
   output logic                         rsp_is_last,
   output logic                         rsp_singular,
   output logic                         rsp_saturated
);
   import mi4_pkg::*;

   q_status_type                         q_status;
   logic                                 push;
   logic                                 pop;
   logic [NUM_ELEMS-1:0][DATA_WIDTH-1:0] push_matrix;
   logic [NUM_ELEMS-1:0][DATA_WIDTH-1:0] head;

   mi4_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_elem_value (req_elem_value),
      .q_status       (q_status),
      .push           (push),
      .push_matrix    (push_matrix)
   );

   mi4_queue #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_matrix (push_matrix),
      .pop         (pop),
      .status      (q_status),
      .head        (head)
   );

   mi4_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inv_value  (rsp_inv_value),
      .rsp_elem_index (rsp_elem_index),
      .rsp_is_last    (rsp_is_last),
      .rsp_singular   (rsp_singular),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
